// File: rtl/core/cpa_pkg.sv
`timescale 1ns / 1ps
// Package for the class pool allocator: sizes, payload structs, outcome codes
// and the memory port structs shared by the core and its two memories.
// Depends on nothing.
package cpa_pkg;

    // sizing
    localparam int UNITS_PER_CLASS = 16;
    localparam int QUEUE_DEPTH     = 16;
    localparam int NUM_CLASSES     = 5;
    localparam int TAG_WIDTH       = 8;

    // fixed field widths
    localparam int CFG_W   = 5;
    localparam int CIDX_W  = 3;
    localparam int CLASS_W = 3;
    localparam int UID_W   = 7;
    localparam int OUTC_W  = 3;

    // derived widths
    localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int UIDX_W  = (UNITS_PER_CLASS > 1) ? $clog2(UNITS_PER_CLASS) : 1;
    localparam int UCNT_W  = $clog2(UNITS_PER_CLASS + 1);
    localparam int QW      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_AW  = $clog2(NUM_CLASSES * QUEUE_DEPTH);
    localparam int BASE_W  = UID_W + 1;

    // outcome codes
    localparam logic [OUTC_W-1:0] OUT_GRANTED  = 3'd0;
    localparam logic [OUTC_W-1:0] OUT_QUEUED   = 3'd1;
    localparam logic [OUTC_W-1:0] OUT_HANDED   = 3'd2;
    localparam logic [OUTC_W-1:0] OUT_FREED    = 3'd3;
    localparam logic [OUTC_W-1:0] OUT_REJECTED = 3'd4;

    // request modes
    localparam logic MODE_ACQUIRE = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [CLASS_W-1:0]   class_size;
        logic [TAG_WIDTH-1:0] requester_tag;
        logic [UID_W-1:0]     unit_id;
    } t_req;

    typedef struct packed {
        logic [OUTC_W-1:0]    outcome;
        logic [UID_W-1:0]     granted_unit;
        logic [TAG_WIDTH-1:0] receiver_tag;
    } t_res;

    // per-class state word
    typedef struct packed {
        logic [UNITS_PER_CLASS-1:0] busy;
        logic [QW-1:0]              head;
        logic [CNT_W-1:0]           count;
    } t_cls_ent;

    typedef struct packed {
        logic             en;
        logic [CLS_W-1:0] addr;
        t_cls_ent         data;
    } t_cls_wr;

    typedef struct packed {
        logic                 en;
        logic [TAG_AW-1:0]    addr;
        logic [TAG_WIDTH-1:0] data;
    } t_tag_wr;

endpackage

// File: rtl/core/class_pool_allocator_fifo_waiters.sv
`timescale 1ns / 1ps
// Class pool allocator with a FIFO of waiters per class. Five classes each own
// units_classN units (saturated at 16), numbered densely across the classes in
// class order. An acquire request gets the lowest free unit of its class or
// waits in that class's ring queue; a release hands the unit to the oldest
// waiter or frees it. Bad class, full queue and invalid unit are rejected.
// One request is in work at a time: a bad class goes from accept straight to
// the result step; grant, queue, free and reject first read the per-class
// state memory, then decide and write back; a hand-off adds a read of the
// waiter tag memory. The result sits in an output register, so a new
// request is accepted while the previous result waits. No clearing pass is
// needed after reset; per-class valid bits stand for the reset state.
// Uses cpa_pkg, cpa_cls_mem and cpa_tag_mem.
module class_pool_allocator_fifo_waiters (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [cpa_pkg::CIDX_W-1:0]  i_cfg_idx,
    input  logic [cpa_pkg::CFG_W-1:0]   i_cfg_data,
    // request channel
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  cpa_pkg::t_req               i_req,
    // result channel
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output cpa_pkg::t_res               o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CLS  = 2'd1;
    localparam logic [1:0] S_TAG  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                        r_state, n_state;
    logic [cpa_pkg::CFG_W-1:0]         r_cfg [cpa_pkg::NUM_CLASSES];
    cpa_pkg::t_req                     r_req;
    logic [cpa_pkg::CLS_W-1:0]         r_k;
    logic [cpa_pkg::BASE_W-1:0]        r_base;
    logic [cpa_pkg::UCNT_W-1:0]        r_n;
    cpa_pkg::t_res                     r_pend, n_pend;
    logic                              r_res_vld, n_res_vld;
    cpa_pkg::t_res                     r_res, n_res;

    logic [cpa_pkg::UCNT_W-1:0]        v_units [cpa_pkg::NUM_CLASSES];
    logic [cpa_pkg::BASE_W-1:0]        v_base  [cpa_pkg::NUM_CLASSES];
    logic [cpa_pkg::CLS_W-1:0]         k_in;
    logic                              cls_bad;
    logic                              req_acc;

    logic                              cls_rd_en;
    cpa_pkg::t_cls_ent                 cls_rd_data;
    cpa_pkg::t_cls_wr                  cls_wr;
    logic                              tag_rd_en;
    logic [cpa_pkg::TAG_AW-1:0]        tag_rd_addr;
    logic [cpa_pkg::TAG_WIDTH-1:0]     tag_rd_data;
    cpa_pkg::t_tag_wr                  tag_wr;

    logic [cpa_pkg::UNITS_PER_CLASS-1:0] v_mask;
    logic [cpa_pkg::UNITS_PER_CLASS-1:0] v_free;
    logic [cpa_pkg::UIDX_W-1:0]          v_low;
    logic [cpa_pkg::CNT_W:0]             v_tsum;
    logic [cpa_pkg::QW-1:0]              v_tail;
    logic [cpa_pkg::QW-1:0]              v_head_nx;
    logic                                v_in_rng;
    logic [cpa_pkg::UIDX_W-1:0]          v_rel;

    // memories
    cpa_cls_mem u_cls_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (cls_rd_en),
        .i_rd_addr (k_in),
        .o_rd_data (cls_rd_data),
        .i_wr      (cls_wr)
    );

    cpa_tag_mem u_tag_mem (
        .i_clk     (i_clk),
        .i_rd_en   (tag_rd_en),
        .i_rd_addr (tag_rd_addr),
        .o_rd_data (tag_rd_data),
        .i_wr      (tag_wr)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < cpa_pkg::NUM_CLASSES; c++) begin
                r_cfg[c] <= '0;
            end
        end else if (i_cfg_we && (int'(i_cfg_idx) < cpa_pkg::NUM_CLASSES)) begin
            r_cfg[i_cfg_idx[cpa_pkg::CLS_W-1:0]] <= i_cfg_data;
        end
    end

    // saturated unit counts and first global id of each class
    always_comb begin
        for (int c = 0; c < cpa_pkg::NUM_CLASSES; c++) begin
            v_units[c] = (int'(r_cfg[c]) > cpa_pkg::UNITS_PER_CLASS) ?
                         cpa_pkg::UCNT_W'(cpa_pkg::UNITS_PER_CLASS) :
                         cpa_pkg::UCNT_W'(r_cfg[c]);
        end
        v_base[0] = '0;
        for (int c = 1; c < cpa_pkg::NUM_CLASSES; c++) begin
            v_base[c] = v_base[c-1] + cpa_pkg::BASE_W'(v_units[c-1]);
        end
    end

    // request decode
    assign k_in    = cpa_pkg::CLS_W'(i_req.class_size - 1'b1);
    assign cls_bad = (i_req.class_size == '0) ||
                     (int'(i_req.class_size) > cpa_pkg::NUM_CLASSES);
    assign req_acc = i_req_valid && o_req_ready;
    assign o_req_ready = (r_state == S_IDLE);

    // request capture
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_req <= i_req;
            r_k   <= k_in;
            if (!cls_bad) begin
                r_base <= v_base[k_in];
                r_n    <= v_units[k_in];
            end
        end
    end

    // free search, ring pointers and release range check
    always_comb begin
        for (int i = 0; i < cpa_pkg::UNITS_PER_CLASS; i++) begin
            v_mask[i] = (i < int'(r_n));
        end
        v_free = ~cls_rd_data.busy & v_mask;
        v_low  = '0;
        for (int i = cpa_pkg::UNITS_PER_CLASS - 1; i >= 0; i--) begin
            if (v_free[i]) begin
                v_low = cpa_pkg::UIDX_W'(i);
            end
        end
        v_tsum = (cpa_pkg::CNT_W+1)'(cls_rd_data.head) + (cpa_pkg::CNT_W+1)'(cls_rd_data.count);
        v_tail = (int'(v_tsum) >= cpa_pkg::QUEUE_DEPTH) ?
                 cpa_pkg::QW'(int'(v_tsum) - cpa_pkg::QUEUE_DEPTH) :
                 cpa_pkg::QW'(v_tsum);
        v_head_nx = (int'(cls_rd_data.head) == cpa_pkg::QUEUE_DEPTH - 1) ?
                    '0 : cls_rd_data.head + 1'b1;
        v_in_rng  = (cpa_pkg::BASE_W'(r_req.unit_id) >= r_base) &&
                    (cpa_pkg::BASE_W'(r_req.unit_id) <
                     r_base + cpa_pkg::BASE_W'(r_n));
        v_rel     = cpa_pkg::UIDX_W'(cpa_pkg::BASE_W'(r_req.unit_id) - r_base);
    end

    // control sequencer
    always_comb begin
        n_state     = r_state;
        n_pend      = r_pend;
        n_res_vld   = r_res_vld;
        n_res       = r_res;
        cls_rd_en   = 1'b0;
        cls_wr      = '0;
        tag_rd_en   = 1'b0;
        tag_rd_addr = cpa_pkg::TAG_AW'(int'(r_k) * cpa_pkg::QUEUE_DEPTH +
                                       int'(cls_rd_data.head));
        tag_wr      = '0;

        if (i_res_ready) begin
            n_res_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_acc) begin
                    if (cls_bad) begin
                        n_pend  = '0;
                        n_pend.outcome = cpa_pkg::OUT_REJECTED;
                        n_state = S_OUT;
                    end else begin
                        cls_rd_en = 1'b1;
                        n_state   = S_CLS;
                    end
                end
            end
            S_CLS: begin
                n_pend      = '0;
                n_pend.outcome = cpa_pkg::OUT_REJECTED;
                n_state     = S_OUT;
                cls_wr.addr = r_k;
                cls_wr.data = cls_rd_data;
                if (r_req.mode == cpa_pkg::MODE_ACQUIRE) begin
                    if (|v_free) begin
                        // grant lowest free unit
                        cls_wr.en = 1'b1;
                        cls_wr.data.busy[v_low] = 1'b1;
                        n_pend.outcome      = cpa_pkg::OUT_GRANTED;
                        n_pend.granted_unit = cpa_pkg::UID_W'(r_base +
                                              cpa_pkg::BASE_W'(v_low));
                        n_pend.receiver_tag = r_req.requester_tag;
                    end else if (int'(cls_rd_data.count) < cpa_pkg::QUEUE_DEPTH) begin
                        // enqueue the waiter at the ring tail
                        cls_wr.en  = 1'b1;
                        cls_wr.data.count = cls_rd_data.count + 1'b1;
                        tag_wr.en   = 1'b1;
                        tag_wr.addr = cpa_pkg::TAG_AW'(int'(r_k) * cpa_pkg::QUEUE_DEPTH +
                                                       int'(v_tail));
                        tag_wr.data = r_req.requester_tag;
                        n_pend.outcome = cpa_pkg::OUT_QUEUED;
                    end
                end else if (v_in_rng && cls_rd_data.busy[v_rel]) begin
                    if (cls_rd_data.count != '0) begin
                        // hand unit to the oldest waiter
                        cls_wr.en = 1'b1;
                        cls_wr.data.head  = v_head_nx;
                        cls_wr.data.count = cls_rd_data.count - 1'b1;
                        tag_rd_en = 1'b1;
                        n_pend.outcome      = cpa_pkg::OUT_HANDED;
                        n_pend.granted_unit = r_req.unit_id;
                        n_state = S_TAG;
                    end else begin
                        cls_wr.en = 1'b1;
                        cls_wr.data.busy[v_rel] = 1'b0;
                        n_pend.outcome      = cpa_pkg::OUT_FREED;
                        n_pend.granted_unit = r_req.unit_id;
                    end
                end
            end
            S_TAG: begin
                n_pend.receiver_tag = tag_rd_data;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_res_vld || i_res_ready) begin
                    n_res     = r_pend;
                    n_res_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

    // class state is only written back in the decide step
    a_cls_wr_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cls_wr.en |-> (r_state == S_CLS))
        else $error("class state written outside decide step");

    // an accepted request goes to the state read or straight to the result
    a_acc_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == S_CLS) || (r_state == S_OUT))
        else $error("accepted request lost");

    // a new result only appears out of the result step
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> ($past(r_state) == S_OUT))
        else $error("result shown without result step");

    // the tag memory is read only for a hand-off
    a_tag_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tag_rd_en |=> (r_state == S_TAG) && (r_pend.outcome == cpa_pkg::OUT_HANDED))
        else $error("tag read without hand-off");

endmodule

// File: rtl/core/cpa_cls_mem.sv
`timescale 1ns / 1ps
// Per-class state memory: busy bits, queue head and queue count per class.
// One read port with registered data, one write port; uses cpa_pkg.
module cpa_cls_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_rd_en,
    input  logic [cpa_pkg::CLS_W-1:0] i_rd_addr,
    output cpa_pkg::t_cls_ent         o_rd_data,
    input  cpa_pkg::t_cls_wr          i_wr
);

    cpa_pkg::t_cls_ent                r_mem [cpa_pkg::NUM_CLASSES];
    logic [cpa_pkg::NUM_CLASSES-1:0]  r_vld;
    cpa_pkg::t_cls_ent                r_rd_data;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // valid bits, an unwritten entry reads as all free with an empty queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.en) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/cpa_tag_mem.sv
`timescale 1ns / 1ps
// Waiter tag ring storage, one ring of QUEUE_DEPTH tags per class.
// One read port with registered data, one write port; uses cpa_pkg.
module cpa_tag_mem (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [cpa_pkg::TAG_AW-1:0]    i_rd_addr,
    output logic [cpa_pkg::TAG_WIDTH-1:0] o_rd_data,
    input  cpa_pkg::t_tag_wr              i_wr
);

    logic [cpa_pkg::TAG_WIDTH-1:0] r_mem [cpa_pkg::NUM_CLASSES * cpa_pkg::QUEUE_DEPTH];
    logic [cpa_pkg::TAG_WIDTH-1:0] r_rd_data;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
